// ===== hdl/step_sequencer_record_play_assert.svh =====
// Assertion macros for the step sequencer.
// Used by the top level only; defining ASSERT_OFF turns the checks into nothing.
`ifndef STEP_SEQUENCER_RECORD_PLAY_ASSERT_SVH
`define STEP_SEQUENCER_RECORD_PLAY_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SSRP_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("step sequencer: same-cycle check failed");

// next-cycle implication
`define SSRP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("step sequencer: next-cycle check failed");

`else

`define SSRP_ASSERT_IMPL(name, clk, rst, ante, cons)
`define SSRP_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/stepseq_pkg.sv =====
// Shared types, codes and constants of the step sequencer.
// No dependencies; imported by the top level, the core, the store and the result buffer.
package stepseq_pkg;

   localparam int STEP_COUNT_DEF = 64;
   localparam logic [15:0] BEAT_TICKS_RESET = 16'd500;
   localparam int GATE_DIVISOR = 4;

   // stored step: rest flag, velocity, note
   localparam int NOTE_W  = 7;
   localparam int ENTRY_W = 15;
   localparam int REST_BIT = 14;
   localparam logic [ENTRY_W-1:0] REST_ENTRY = ENTRY_W'(1) << REST_BIT;

   typedef enum logic [1:0] {
      FN_TICK = 2'd0,
      FN_KEY  = 2'd1,
      FN_REST = 2'd2,
      FN_MODE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      MD_OFF  = 2'd0,
      MD_PLAY = 2'd1,
      MD_REC  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      EV_GATE_ON  = 2'd0,
      EV_GATE_OFF = 2'd1,
      EV_ALL_OFF  = 2'd2
   } event_type;

   typedef struct packed {
      logic [1:0]        event_res;
      logic              sounding;
      logic [NOTE_W-1:0] out_note;
      logic [NOTE_W-1:0] out_velocity;
      logic              last;
   } result_type;

   // core -> result buffer
   typedef struct packed {
      logic       load;
      logic       two;
      result_type res0;
      result_type res1;
   } push_type;

   // core status seen by the checks
   typedef struct packed {
      mode_type mode;
      logic     pidx_zero;
   } status_type;

   function automatic result_type make_result(event_type ev, logic [ENTRY_W-1:0] entry,
                                              logic use_entry);
      result_type r;
      r = '0;
      r.event_res = ev;
      if (use_entry && !entry[REST_BIT]) begin
         r.sounding     = 1'b1;
         r.out_note     = entry[NOTE_W-1:0];
         r.out_velocity = entry[2*NOTE_W-1:NOTE_W];
      end
      return r;
   endfunction

endpackage

// ===== hdl/stepseq_if.sv =====
// Channel interfaces of the step sequencer: input items, results, register write.
// Plain valid/ready channels; no package dependency.
interface stepseq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [1:0] mode;
   logic [6:0] note;
   logic [6:0] velocity;
   logic       is_note_on;
   modport source (output valid, func, mode, note, velocity, is_note_on, input ready);
   modport sink (input valid, func, mode, note, velocity, is_note_on, output ready);
endinterface

interface stepseq_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_res;
   logic       sounding;
   logic [6:0] out_note;
   logic [6:0] out_velocity;
   logic       last;
   modport source (output valid, event_res, sounding, out_note, out_velocity, last,
                   input ready);
   modport sink (input valid, event_res, sounding, out_note, out_velocity, last,
                 output ready);
endinterface

interface stepseq_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] beat_ticks;
   modport source (output valid, beat_ticks, input ready);
   modport sink (input valid, beat_ticks, output ready);
endinterface

// ===== hdl/step_sequencer_record_play.sv =====
// Channel    Direction  Payload
// req_chan   in         func, mode, note, velocity, is_note_on
// rsp_chan   out        event_res, sounding, out_note, out_velocity, last
// csr_chan   in         beat_ticks
//
// One transaction per cycle enters the input register unless it is held; its state
// update goes into the state registers and its results into the result buffer.
// Results leave one per cycle while the sink is ready. A transaction with results
// waits in the input register while a stalled sink holds earlier results, and after
// one with two results until the first of those has left. Reset is synchronous; the
// step store needs no clearing pass (a fill count masks old entries).
//
// Top level of the step sequencer: register write port, core, store, result buffer.
// Depends on stepseq_pkg, the channel interfaces and the assertion header.
`include "step_sequencer_record_play_assert.svh"

module step_sequencer_record_play #(
   parameter int STEP_COUNT = stepseq_pkg::STEP_COUNT_DEF
) (
   input  logic            clock,
   input  logic            reset,
   stepseq_req_if.sink     req_chan,
   stepseq_rsp_if.source   rsp_chan,
   stepseq_csr_if.sink     csr_chan
);
   import stepseq_pkg::*;

   localparam int IDX_W = $clog2(STEP_COUNT);

   logic [15:0]        beat_ticks_ff;
   logic               out_free;
   logic [ENTRY_W-1:0] entry;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [IDX_W-1:0]   rd_addr;
   push_type           push;
   status_type         status;

   // beat length register
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ticks_ff <= BEAT_TICKS_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         beat_ticks_ff <= csr_chan.beat_ticks;
      end
   end

   stepseq_core #(.STEP_COUNT(STEP_COUNT)) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .beat_ticks (beat_ticks_ff),
      .out_free   (out_free),
      .entry      (entry),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .push       (push),
      .status     (status)
   );

   stepseq_store #(.STEP_COUNT(STEP_COUNT)) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .entry   (entry)
   );

   stepseq_out u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

   // checks
   `SSRP_ASSERT_IMPL(a_load_needs_room, clock, reset, push.load, out_free)
   `SSRP_ASSERT_NEXT(a_load_shows_result, clock, reset, push.load, rsp_chan.valid)
   `SSRP_ASSERT_IMPL(a_pidx_parked, clock, reset, status.mode != MD_PLAY, status.pidx_zero)

endmodule

// ===== hdl/stepseq_store.sv =====
// Step store: one write port, one registered read port that follows the play index.
// Depends on stepseq_pkg. A fill count stands in for clearing the memory.
module stepseq_store #(
   parameter int STEP_COUNT = stepseq_pkg::STEP_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [$clog2(STEP_COUNT)-1:0]    wr_addr,
   input  logic [stepseq_pkg::ENTRY_W-1:0]  wr_data,
   input  logic [$clog2(STEP_COUNT)-1:0]    rd_addr,
   output logic [stepseq_pkg::ENTRY_W-1:0]  entry
);
   import stepseq_pkg::*;

   localparam int FILL_W = $clog2(STEP_COUNT + 1);

   logic [ENTRY_W-1:0] mem [STEP_COUNT];
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  wr_end;
   logic               rd_written;
   logic [ENTRY_W-1:0] entry_ff;

   // writes always run upward from 0, so the written entries form a prefix
   assign wr_end     = FILL_W'(wr_addr) + FILL_W'(1);
   assign fill_in    = (wr_en && (wr_end > fill_ff)) ? wr_end : fill_ff;
   assign rd_written = FILL_W'(rd_addr) < fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read register, with bypass of a write to the same step
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (!rd_written) begin
         entry_ff <= '0;
      end else if (wr_en && (wr_addr == rd_addr)) begin
         entry_ff <= wr_data;
      end else begin
         entry_ff <= mem[rd_addr];
      end
   end

   assign entry = entry_ff;

endmodule

// ===== hdl/stepseq_core.sv =====
// Input register and per-transaction state update: record, play timing, mode changes.
// Depends on stepseq_pkg and stepseq_req_if; reads the store and feeds the result buffer.
module stepseq_core #(
   parameter int STEP_COUNT = stepseq_pkg::STEP_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   stepseq_req_if.sink                      req_chan,
   input  logic [15:0]                      beat_ticks,
   input  logic                             out_free,
   input  logic [stepseq_pkg::ENTRY_W-1:0]  entry,
   output logic                             wr_en,
   output logic [$clog2(STEP_COUNT)-1:0]    wr_addr,
   output logic [stepseq_pkg::ENTRY_W-1:0]  wr_data,
   output logic [$clog2(STEP_COUNT)-1:0]    rd_addr,
   output stepseq_pkg::push_type            push,
   output stepseq_pkg::status_type          status
);
   import stepseq_pkg::*;

   localparam int IDX_W = $clog2(STEP_COUNT);
   localparam int REC_W = $clog2(STEP_COUNT + 1);

   // input register
   logic        in_vld_ff;
   logic [1:0]  in_func_ff;
   logic [1:0]  in_mode_ff;
   logic [6:0]  in_note_ff;
   logic [6:0]  in_vel_ff;
   logic        in_on_ff;

   // sequencer state
   mode_type          mode_ff, mode_in;
   logic [REC_W-1:0]  rec_ff, rec_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic [IDX_W-1:0]  lend_ff, lend_in;
   logic [15:0]       beat_ff, beat_in;
   logic [15:0]       gate_ff, gate_in;
   logic              armed_ff, armed_in;

   logic              proc;
   logic              wr_req;
   logic [1:0]        n_res;
   result_type        res0, res1;

   assign proc = in_vld_ff && ((n_res == 2'd0) || out_free);
   assign req_chan.ready = !in_vld_ff || proc;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_func_ff <= req_chan.func;
         in_mode_ff <= req_chan.mode;
         in_note_ff <= req_chan.note;
         in_vel_ff  <= req_chan.velocity;
         in_on_ff   <= req_chan.is_note_on;
      end
   end

   // next state and results of the transaction in the input register
   always_comb begin
      logic             store_it;
      logic [IDX_W:0]   nxt;
      result_type       r;

      mode_in  = mode_ff;
      rec_in   = rec_ff;
      pidx_in  = pidx_ff;
      lend_in  = lend_ff;
      beat_in  = beat_ff;
      gate_in  = gate_ff;
      armed_in = armed_ff;
      wr_req   = 1'b0;
      wr_addr  = rec_ff[IDX_W-1:0];
      wr_data  = '0;
      n_res    = 2'd0;
      res0     = '0;
      res1     = '0;
      store_it = 1'b0;
      nxt      = '0;
      r        = '0;

      case (func_type'(in_func_ff))
         FN_TICK: begin
            if (beat_ff != 16'd0) beat_in = beat_ff - 16'd1;
            if (gate_ff != 16'd0) gate_in = gate_ff - 16'd1;
         end
         FN_KEY: begin
            store_it = (mode_ff == MD_REC) && in_on_ff;
            wr_data  = {1'b0, in_vel_ff, in_note_ff};
         end
         FN_REST: begin
            store_it = (mode_ff == MD_REC);
            wr_data  = REST_ENTRY;
         end
         FN_MODE: begin
            case (in_mode_ff)
               MD_OFF: begin
                  if (mode_ff != MD_OFF) begin
                     mode_in = MD_OFF;
                     res0    = make_result(EV_ALL_OFF, '0, 1'b0);
                     n_res   = 2'd1;
                  end
               end
               MD_PLAY: begin
                  // play index is already parked at 0 outside play
                  mode_in = MD_PLAY;
               end
               MD_REC: begin
                  if (mode_ff != MD_REC) begin
                     mode_in = MD_REC;
                     rec_in  = '0;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      // record a step unless the store is full
      if (store_it && (rec_ff < REC_W'(STEP_COUNT))) begin
         wr_req  = 1'b1;
         lend_in = rec_ff[IDX_W-1:0];
         rec_in  = rec_ff + REC_W'(1);
      end

      // play timing: beat start, then gate end
      if (mode_in == MD_PLAY) begin
         if (beat_in == 16'd0) begin
            beat_in  = beat_ticks;
            gate_in  = 16'(beat_ticks / GATE_DIVISOR);
            armed_in = 1'b1;
            r = make_result(EV_GATE_ON, entry, 1'b1);
            if (n_res == 2'd0) res0 = r; else res1 = r;
            n_res = n_res + 2'd1;
         end
         if (armed_in && (gate_in == 16'd0)) begin
            armed_in = 1'b0;
            r = make_result(EV_GATE_OFF, entry, 1'b1);
            if (n_res == 2'd0) res0 = r; else res1 = r;
            n_res = n_res + 2'd1;
            nxt = {1'b0, pidx_ff} + (IDX_W + 1)'(1);
            if ((nxt > {1'b0, lend_in}) || (nxt >= (IDX_W + 1)'(STEP_COUNT))) begin
               pidx_in = '0;
            end else begin
               pidx_in = nxt[IDX_W-1:0];
            end
         end
      end else begin
         pidx_in = '0;
      end

      // mark the final result
      if (n_res == 2'd1) res0.last = 1'b1;
      if (n_res == 2'd2) res1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MD_OFF;
         rec_ff   <= '0;
         pidx_ff  <= '0;
         lend_ff  <= '0;
         beat_ff  <= '0;
         gate_ff  <= '0;
         armed_ff <= 1'b0;
      end else if (proc) begin
         mode_ff  <= mode_in;
         rec_ff   <= rec_in;
         pidx_ff  <= pidx_in;
         lend_ff  <= lend_in;
         beat_ff  <= beat_in;
         gate_ff  <= gate_in;
         armed_ff <= armed_in;
      end
   end

   // store keeps its read register on the play index of the next cycle
   assign wr_en   = proc && wr_req;
   assign rd_addr = proc ? pidx_in : pidx_ff;

   assign push.load = proc && (n_res != 2'd0);
   assign push.two  = (n_res == 2'd2);
   assign push.res0 = res0;
   assign push.res1 = res1;

   assign status.mode      = mode_ff;
   assign status.pidx_zero = (pidx_ff == '0);

endmodule

// ===== hdl/stepseq_out.sv =====
// Result buffer: holds the one or two results of a transaction and hands them out in order.
// Depends on stepseq_pkg and stepseq_rsp_if.
module stepseq_out (
   input  logic                   clock,
   input  logic                   reset,
   input  stepseq_pkg::push_type  push,
   output logic                   out_free,
   stepseq_rsp_if.source          rsp_chan
);
   import stepseq_pkg::*;

   result_type slot0_ff, slot1_ff;
   logic [1:0] cnt_ff;
   logic       pop;

   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign out_free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_chan.ready);

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (push.load) begin
         cnt_ff <= push.two ? 2'd2 : 2'd1;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   // payload, head is slot 0
   always_ff @(posedge clock) begin
      if (push.load) begin
         slot0_ff <= push.res0;
         slot1_ff <= push.res1;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

   assign rsp_chan.valid        = (cnt_ff != 2'd0);
   assign rsp_chan.event_res    = slot0_ff.event_res;
   assign rsp_chan.sounding     = slot0_ff.sounding;
   assign rsp_chan.out_note     = slot0_ff.out_note;
   assign rsp_chan.out_velocity = slot0_ff.out_velocity;
   assign rsp_chan.last         = slot0_ff.last;

endmodule
